>>> hdl/frfir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frfir_pkg
// Shared types and constants of the fractional resampler.
// ----------------------------------------------------------------------------
package frfir_pkg;

    localparam int TAPS         = 6;
    localparam int PHASES       = 32;
    localparam int MAX_LOG2_FFT = 11;
    localparam int SAMPLE_BITS  = 16;
    localparam int COEF_BITS    = 18;

    localparam int FRAC_BITS = 16;
    localparam int ACC_BITS  = 19;
    localparam int CNT_BITS  = 12;
    localparam int IDX_BITS  = 8;
    localparam int FLEN_BITS = 12;
    localparam int LOG_BITS  = 4;
    localparam int OIDX_BITS = 11;

    localparam logic [0:0] OP_LOAD   = 1'b0;
    localparam logic [0:0] OP_SAMPLE = 1'b1;

    localparam logic [0:0] REG_FRAME_LEN = 1'b0;
    localparam logic [0:0] REG_FFT_LOG2  = 1'b1;

    // Job handed from the front end to the filter engine
    typedef struct packed {
        logic                 is_load;
        logic [IDX_BITS-1:0]  coef_index;
        logic [23:0]          coef_value;
        logic [23:0]          sample_re;
        logic [23:0]          sample_im;
    } job_t;

endpackage : frfir_pkg
`default_nettype wire

>>> hdl/frfir_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frfir_queue
// Two-entry queue between front end and filter engine.
// ----------------------------------------------------------------------------
module frfir_queue
    import frfir_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   in_valid,
    output logic  in_ready,
    input  job_t  in_job,
    output logic  out_valid,
    input  wire   out_ready,
    output job_t  out_job
);

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> cnt_reg == $past(cnt_reg) - 2'd1) else $error("pop");
`endif

endmodule : frfir_queue
`default_nettype wire

>>> hdl/frfir_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frfir_engine
// Filter engine: coefficient memory, delay line, per-tap sequenced MAC.
// ----------------------------------------------------------------------------
module frfir_engine
    import frfir_pkg::*;
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire [FLEN_BITS-1:0]           frame_len,
    input  wire [LOG_BITS-1:0]            fft_log2,
    input  wire                           job_valid,
    output logic                          job_ready,
    input  job_t                          job,
    output logic                          res_valid,
    input  wire                           res_ready,
    output logic signed [SAMPLE_BITS-1:0] res_re,
    output logic signed [SAMPLE_BITS-1:0] res_im,
    output logic [OIDX_BITS-1:0]          res_index,
    output logic                          res_last_run,
    output logic                          res_last_frame
);

    localparam int TSIZE  = TAPS * PHASES;
    localparam int TA_W   = $clog2(TSIZE);
    localparam int PH_W   = $clog2(PHASES);
    localparam int TAP_W  = $clog2(TAPS + 1);
    localparam int PR_W   = SAMPLE_BITS + COEF_BITS + 1;
    localparam int SUM_W  = PR_W + 5;
    localparam int CR_W   = SAMPLE_BITS + COEF_BITS + FRAC_BITS + 3;
    localparam int ONE    = 1 << FRAC_BITS;
    localparam logic [ACC_BITS-1:0] ACC_INIT =
        ACC_BITS'((TAPS + 1) * ONE + ONE / 2);
    localparam logic [LOG_BITS-1:0] LG_MAX = LOG_BITS'(MAX_LOG2_FFT);

    localparam logic [2:0] S_IDLE = 3'd0, S_ADDR = 3'd1, S_RD = 3'd2,
                           S_INT = 3'd3, S_MUL = 3'd4, S_ACC = 3'd5,
                           S_CORR = 3'd6, S_OUT = 3'd7;

    logic signed [COEF_BITS-1:0]   coef_mem [TSIZE];
    logic signed [SAMPLE_BITS-1:0] dre_reg [TAPS+1];
    logic signed [SAMPLE_BITS-1:0] dim_reg [TAPS+1];

    logic [2:0]          state_reg, state_next;
    logic [ACC_BITS-1:0] acc_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [TAP_W-1:0]    k_reg;
    logic [1:0]          n_reg;
    logic                wrap_reg;
    logic [PH_W-1:0]     p_reg;
    logic [FRAC_BITS-1:0] d_reg;
    logic signed [COEF_BITS-1:0] c1_reg, c2_reg, c_reg;
    logic signed [COEF_BITS+FRAC_BITS+1:0] ip_reg;
    logic signed [SUM_W-1:0] sre_reg, sim_reg;
    logic signed [SAMPLE_BITS:0] dfr_reg, dfi_reg;
    logic signed [SAMPLE_BITS+COEF_BITS+1:0] cmr_reg, cmi_reg;
    logic [1:0] corr_reg;

    // result register
    logic                          ov_reg;
    logic signed [SAMPLE_BITS-1:0] ore_reg, oim_reg;
    logic [OIDX_BITS-1:0]          oidx_reg;
    logic                          olr_reg, olf_reg;

    // clamped geometry
    logic [LOG_BITS-1:0]   lg;
    logic [CNT_BITS:0]     flen;
    logic [CNT_BITS:0]     fl;
    logic [ACC_BITS-1:0]   delta;
    logic [CNT_BITS+FRAC_BITS:0] fl_sh;

    always_comb
    begin
        lg = fft_log2;
        if (lg < LOG_BITS'(1)) lg = LOG_BITS'(1);
        if (lg > LG_MAX) lg = LG_MAX;
        flen = (CNT_BITS+1)'(1) << lg;
        fl = {1'b0, frame_len};
        if (fl > flen) fl = flen;
        if (fl <= (flen >> 1)) fl = (flen >> 1) + (CNT_BITS+1)'(1);
        fl_sh = {fl, {FRAC_BITS{1'b0}}} >> lg;
        delta = ACC_BITS'(fl_sh);
    end

    logic [ACC_BITS+PH_W-1:0] scaled;
    assign scaled = {{PH_W{1'b0}}, acc_reg} * (ACC_BITS+PH_W)'(PHASES);

    logic signed [SUM_W-1:0] rnd_re, rnd_im;
    logic signed [SUM_W-1:0] hi_lim, lo_lim;
    assign rnd_re = (sre_reg + (SUM_W'(1) <<< (COEF_BITS-2))) >>> (COEF_BITS-1);
    assign rnd_im = (sim_reg + (SUM_W'(1) <<< (COEF_BITS-2))) >>> (COEF_BITS-1);
    assign hi_lim = (SUM_W'(1) <<< (SAMPLE_BITS-1)) - SUM_W'(1);
    assign lo_lim = -hi_lim - SUM_W'(1);

    function automatic logic signed [SAMPLE_BITS-1:0] sat(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] hi,
        input logic signed [SUM_W-1:0] lo);
        logic signed [SUM_W-1:0] r;
        r = v;
        if (v > hi) r = hi;
        if (v < lo) r = lo;
        return SAMPLE_BITS'(r);
    endfunction

    logic frame_done;
    assign frame_done = ({1'b0, cnt_reg} >= flen - (CNT_BITS+1)'(1));

    assign job_ready = (state_reg == S_IDLE) && !ov_reg;
    logic take;
    assign take = job_valid && job_ready;

    assign res_valid      = ov_reg;
    assign res_re         = ore_reg;
    assign res_im         = oim_reg;
    assign res_index      = oidx_reg;
    assign res_last_run   = olr_reg;
    assign res_last_frame = olf_reg;

    logic [TA_W-1:0] a1_n, a2_n;
    always_comb
    begin
        if (!wrap_reg)
        begin
            a1_n = TA_W'(k_reg * PHASES + p_reg);
            a2_n = TA_W'(k_reg * PHASES + p_reg + 1);
        end
        else if (k_reg < TAP_W'(TAPS - 1))
        begin
            a1_n = TA_W'(k_reg * PHASES + PHASES - 1);
            a2_n = TA_W'((k_reg + 1) * PHASES);
        end
        else
        begin
            a1_n = TA_W'(TSIZE - 1);
            a2_n = '0;
        end
        // correction pass reads entry 0
        if (corr_reg != 2'd0)
        begin
            a1_n = '0;
            a2_n = '0;
        end
    end

    // coefficient memory, registered read; data is valid in the state after S_RD
    always_ff @(posedge clk)
    begin
        if (take && job.is_load && job.coef_index < IDX_BITS'(TSIZE))
        begin
            coef_mem[TA_W'(job.coef_index)] <= job.coef_value[COEF_BITS-1:0];
        end
        c1_reg <= coef_mem[a1_n];
        c2_reg <= coef_mem[a2_n];
    end

    logic pend;
    assign pend = (acc_reg < ACC_BITS'(ONE)) && (n_reg < 2'd2);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (take && !job.is_load) state_next = S_ADDR;
            S_ADDR: state_next = pend ? S_RD : S_IDLE;
            S_RD:   state_next = S_INT;
            S_INT:  state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:
                if (corr_reg != 2'd0) state_next = S_OUT;
                else if (k_reg == TAP_W'(TAPS - 1))
                    state_next = wrap_reg ? S_CORR : S_OUT;
                else state_next = S_RD;
            S_CORR: state_next = S_RD;
            S_OUT:  if (!ov_reg) state_next = S_ADDR;
            default: state_next = S_IDLE;
        endcase
    end

    logic signed [COEF_BITS:0] cdiff;
    assign cdiff = {c2_reg[COEF_BITS-1], c2_reg} - {c1_reg[COEF_BITS-1], c1_reg};

    logic signed [PR_W-1:0] prod_re, prod_im;
    assign prod_re = dre_reg[k_reg + TAP_W'(1)] * c_reg;
    assign prod_im = dim_reg[k_reg + TAP_W'(1)] * c_reg;

    logic signed [CR_W-1:0] cor_re, cor_im;
    assign cor_re = cmr_reg * $signed({1'b0, d_reg});
    assign cor_im = cmi_reg * $signed({1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= ACC_INIT;
            cnt_reg   <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            corr_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i <= TAPS; i++)
            begin
                dre_reg[i] <= '0;
                dim_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && res_ready) ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (take && !job.is_load)
                    begin
                        n_reg <= '0;
                        if (acc_reg >= ACC_BITS'(ONE))
                        begin
                            for (int i = 1; i <= TAPS; i++)
                            begin
                                dre_reg[i] <= dre_reg[i-1];
                                dim_reg[i] <= dim_reg[i-1];
                            end
                            dre_reg[0] <= job.sample_re[SAMPLE_BITS-1:0];
                            dim_reg[0] <= job.sample_im[SAMPLE_BITS-1:0];
                            acc_reg <= acc_reg - ACC_BITS'(ONE);
                        end
                    end
                S_ADDR:
                begin
                    p_reg    <= PH_W'(scaled >> FRAC_BITS);
                    d_reg    <= scaled[FRAC_BITS-1:0];
                    wrap_reg <= (scaled >> FRAC_BITS) >= (ACC_BITS+PH_W)'(PHASES-1);
                    k_reg    <= '0;
                    corr_reg <= '0;
                    sre_reg  <= '0;
                    sim_reg  <= '0;
                end
                S_INT:
                    ip_reg <= cdiff * $signed({1'b0, d_reg});
                S_MUL:
                begin
                    if (corr_reg == 2'd0)
                    begin
                        c_reg <= COEF_BITS'(c1_reg +
                            ((ip_reg + (1 <<< (FRAC_BITS-1))) >>> FRAC_BITS));
                    end
                    else
                    begin
                        cmr_reg <= dfr_reg * c1_reg;
                        cmi_reg <= dfi_reg * c1_reg;
                    end
                end
                S_ACC:
                begin
                    if (corr_reg == 2'd0)
                    begin
                        sre_reg <= sre_reg + SUM_W'(prod_re);
                        sim_reg <= sim_reg + SUM_W'(prod_im);
                        if (k_reg != TAP_W'(TAPS - 1)) k_reg <= k_reg + TAP_W'(1);
                    end
                    else
                    begin
                        sre_reg <= sre_reg + SUM_W'((cor_re
                            + (1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
                        sim_reg <= sim_reg + SUM_W'((cor_im
                            + (1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
                    end
                end
                S_CORR:
                begin
                    corr_reg <= 2'd1;
                    dfr_reg <= dre_reg[0] - dre_reg[TAPS];
                    dfi_reg <= dim_reg[0] - dim_reg[TAPS];
                end
                S_OUT:
                    if (!ov_reg)
                    begin
                        ov_reg   <= 1'b1;
                        ore_reg  <= sat(rnd_re, hi_lim, lo_lim);
                        oim_reg  <= sat(rnd_im, hi_lim, lo_lim);
                        oidx_reg <= OIDX_BITS'(cnt_reg);
                        olf_reg  <= frame_done;
                        if (frame_done)
                        begin
                            olr_reg <= 1'b1;
                            acc_reg <= ACC_INIT;
                            cnt_reg <= '0;
                            n_reg   <= 2'd2;
                            for (int i = 0; i <= TAPS; i++)
                            begin
                                dre_reg[i] <= '0;
                                dim_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            n_reg   <= n_reg + 2'd1;
                            olr_reg <= (n_reg == 2'd1) ||
                                       ((acc_reg + delta) >= ACC_BITS'(ONE));
                            acc_reg <= acc_reg + delta;
                            cnt_reg <= cnt_reg + CNT_BITS'(1);
                        end
                    end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !job_ready) else $error("take while busy");
    a_two_max: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg != 2'd3) else $error("too many results");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !res_ready |=> ov_reg && $stable(ore_reg)) else $error("result lost");
`endif

endmodule : frfir_engine
`default_nettype wire

>>> hdl/fractional_resampler_interp_fir.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fractional_resampler_interp_fir
// Polyphase fractional resampler with interpolated FIR coefficients.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis: one transaction per item; tuser = op (0 coefficient load,
//  1 sample). tdata holds coef_index, coef_value, sample_re, sample_im.
//  m_axis: up to two results per sample; tdata = out_re, out_im, out_index,
//  tlast marks the last result of a sample, tuser the last of a frame.
//  cfg: register 0 frame_len, register 1 fft_log2, write while idle.
// Flow: the front end queues two items; the engine walks the taps one
//  by one, each tap through the read, interpolate, multiply and
//  accumulate states, with a correction pass at the last phase. The
//  engine takes a new input only once it is idle and its result
//  register is empty.
// Reset clears the delay line, phase and counters; the coefficient table
//  must be loaded before use. A stalled receiver holds the result register
//  and the engine waits; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module fractional_resampler_interp_fir
    import frfir_pkg::*;
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // coef_index, coef_value, sample_re, sample_im (low bits first)
    input  wire [((8+COEF_BITS+2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  wire                               s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // out_re, out_im, out_index (low bits first)
    output logic [((2*SAMPLE_BITS+11+7)/8)*8-1:0] m_axis_tdata,
    output logic                              m_axis_tlast,
    // last_of_frame
    output logic                              m_axis_tuser,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [0:0]                         cfg_index,
    input  wire [FLEN_BITS-1:0]               cfg_data
);

    localparam int OW = ((2*SAMPLE_BITS+11+7)/8)*8;

    logic [FLEN_BITS-1:0] frame_len_reg;
    logic [LOG_BITS-1:0]  fft_log2_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= FLEN_BITS'(12);
            fft_log2_reg  <= LOG_BITS'(4);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_FRAME_LEN) frame_len_reg <= cfg_data;
            if (cfg_index == REG_FFT_LOG2)  fft_log2_reg  <= cfg_data[LOG_BITS-1:0];
        end
    end

    job_t in_job, q_job;
    logic q_valid, q_ready;

    always_comb
    begin
        in_job = '0;
        in_job.is_load    = (s_axis_tuser == OP_LOAD);
        in_job.coef_index = s_axis_tdata[7:0];
        in_job.coef_value = 24'(s_axis_tdata[8 +: COEF_BITS]);
        in_job.sample_re  = 24'(s_axis_tdata[8+COEF_BITS +: SAMPLE_BITS]);
        in_job.sample_im  = 24'(s_axis_tdata[8+COEF_BITS+SAMPLE_BITS +: SAMPLE_BITS]);
    end

    frfir_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_job(in_job),
        .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
    );

    logic signed [SAMPLE_BITS-1:0] r_re, r_im;
    logic [OIDX_BITS-1:0] r_idx;

    frfir_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .frame_len(frame_len_reg), .fft_log2(fft_log2_reg),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_re(r_re), .res_im(r_im), .res_index(r_idx),
        .res_last_run(m_axis_tlast), .res_last_frame(m_axis_tuser)
    );

    assign m_axis_tdata = OW'({r_idx, r_im, r_re});

`ifndef NO_ASSERTIONS
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready) else $error("cfg not ready");
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == REG_FFT_LOG2 |=> fft_log2_reg == $past(cfg_data[3:0]))
        else $error("cfg write");
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_valid |=> $stable(frame_len_reg)) else $error("cfg changed");
`endif

endmodule : fractional_resampler_interp_fir
`default_nettype wire
